FILE: hdl/sdf_pkg.sv
package sdf_pkg;

  localparam int IN_WIDTH   = 64;
  localparam int NUM_DIGITS = 20;
  localparam int IDX_WIDTH  = $clog2(NUM_DIGITS);
  localparam int CHAR_WIDTH = 6;
  localparam int LEN_WIDTH  = 5;

  localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;

  typedef logic [3:0] digit_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit_sign;
    logic emit_digit;
  } cmd_t;

  typedef struct packed {
    logic negative;
    logic last_digit;
  } stat_t;

endpackage

FILE: hdl/signed_decimal_formatter_top.sv
// Signed decimal formatter.
// Command port: a word on value is taken at a rising edge where start is high
// and busy is low. Only the low VALUE_WIDTH bits are used, the top one of
// them being the sign bit.
// Result port: one character a cycle, each shown for exactly one cycle with
// strobe high; character is the ASCII code, text_length the length of the
// whole text (sign included) and is_last marks the final character.
// Sequence: the magnitude is converted to BCD by shift-and-add-three, one bit
// a cycle. The minus sign, when present, is sent next, then the digits,
// most significant first. busy stays high until the last character is
// registered. The receiver cannot stall the block.
// Reset: rst clears the controller and the strobe; no result is in flight
// afterwards and busy is low.
module signed_decimal_formatter_top
  import sdf_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [IN_WIDTH-1:0]   value,
  output logic                  strobe,
  output logic [CHAR_WIDTH-1:0] character,
  output logic [LEN_WIDTH-1:0]  text_length,
  output logic                  is_last
);

  cmd_t  cmd;
  stat_t stat;

  sdf_ctrl #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  sdf_dpath #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .value       (value),
    .cmd         (cmd),
    .stat        (stat),
    .strobe      (strobe),
    .character   (character),
    .text_length (text_length),
    .is_last     (is_last)
  );

endmodule

FILE: hdl/sdf_ctrl.sv
module sdf_ctrl
  import sdf_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  start,
  output logic  busy,
  output cmd_t  cmd,
  input  stat_t stat
);

  localparam int CW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
  localparam logic [CW-1:0] BITS_LAST = CW'(VALUE_WIDTH - 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SIGN = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t        state, state_next;
  logic [CW-1:0] count, count_next;

  always_comb begin
    state_next = state;
    count_next = count;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          count_next = BITS_LAST;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.shift  = 1'b1;
        count_next = count - 1'b1;
        if (count == '0) begin
          state_next = stat.negative ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        cmd.emit_sign = 1'b1;
        state_next    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit_digit = 1'b1;
        if (stat.last_digit) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      state <= state_next;
      count <= count_next;
    end
  end

  assign busy = (state != S_IDLE);

endmodule

FILE: hdl/sdf_dpath.sv
module sdf_dpath
  import sdf_pkg::*;
#(
  parameter int VALUE_WIDTH = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [IN_WIDTH-1:0]   value,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic                  strobe,
  output logic [CHAR_WIDTH-1:0] character,
  output logic [LEN_WIDTH-1:0]  text_length,
  output logic                  is_last
);

  logic [VALUE_WIDTH-1:0] mag, mag_next;
  digit_t                 bcd [NUM_DIGITS];
  digit_t                 bcd_next [NUM_DIGITS];
  digit_t                 fixed [NUM_DIGITS];
  logic [LEN_WIDTH-1:0]   ndig, ndig_next;
  logic [IDX_WIDTH-1:0]   ptr, ptr_next;
  logic                   neg, neg_next;
  logic [VALUE_WIDTH-1:0] raw;
  logic [IDX_WIDTH-1:0]   top;
  digit_t                 cur;

  assign raw = value[VALUE_WIDTH-1:0];
  assign top = IDX_WIDTH'(ndig - 1'b1);
  assign cur = bcd[ptr];

  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      fixed[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
  end

  always_comb begin
    mag_next  = mag;
    bcd_next  = bcd;
    ndig_next = ndig;
    ptr_next  = ptr;
    neg_next  = neg;
    if (cmd.load) begin
      neg_next  = raw[VALUE_WIDTH-1];
      mag_next  = raw[VALUE_WIDTH-1] ? (~raw + 1'b1) : raw;
      ndig_next = LEN_WIDTH'(1);
      ptr_next  = '0;
      for (int i = 0; i < NUM_DIGITS; i++) begin
        bcd_next[i] = '0;
      end
    end else if (cmd.shift) begin
      mag_next    = mag << 1;
      bcd_next[0] = {fixed[0][2:0], mag[VALUE_WIDTH-1]};
      for (int i = 1; i < NUM_DIGITS; i++) begin
        bcd_next[i] = {fixed[i][2:0], fixed[i-1][3]};
      end
      ndig_next = ndig + LEN_WIDTH'(fixed[top][3]);
      ptr_next  = IDX_WIDTH'(ndig_next - 1'b1);
    end else if (cmd.emit_digit) begin
      ptr_next = ptr - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    mag  <= mag_next;
    bcd  <= bcd_next;
    ndig <= ndig_next;
    ptr  <= ptr_next;
    neg  <= neg_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.emit_sign | cmd.emit_digit;
    end
  end

  always_ff @(posedge clk) begin
    character   <= cmd.emit_sign ? CHAR_MINUS : CHAR_ZERO + {2'b00, cur};
    text_length <= ndig + LEN_WIDTH'(neg);
    is_last     <= cmd.emit_digit && (ptr == '0);
  end

  assign stat.negative   = neg;
  assign stat.last_digit = (ptr == '0);

endmodule
